// ===== rtl/rlkpc_pkg.sv =====
// shared types, constants and thresholds for the resistor ladder key classifier
package rlkpc_pkg;

   // time and sample widths
   localparam int unsigned TimeBits   = 32;
   localparam int unsigned SampleBits = 12;

   // key counts per ladder
   localparam int unsigned NumKeysA = 4;
   localparam int unsigned NumKeysB = 5;
   localparam int unsigned NumKeys  = NumKeysA + NumKeysB;

   // full scale code and ladder limits, volts times 100 scaled to codes
   localparam int unsigned SampleFull = (2 ** SampleBits) - 1;
   localparam int unsigned Thr050     = (50  * SampleFull) / 330;
   localparam int unsigned Thr135     = (135 * SampleFull) / 330;
   localparam int unsigned Thr170     = (170 * SampleFull) / 330;
   localparam int unsigned Thr210     = (210 * SampleFull) / 330;
   localparam int unsigned Thr240     = (240 * SampleFull) / 330;
   localparam int unsigned Thr300     = (300 * SampleFull) / 330;

   // key codes
   localparam logic [2:0] KeyNone    = 3'd0;
   localparam logic [2:0] KeyA1      = 3'd1;
   localparam logic [2:0] KeyA2      = 3'd2;
   localparam logic [2:0] KeyA3      = 3'd3;
   localparam logic [2:0] KeyA4      = 3'd4;
   localparam logic [2:0] KeyBDown   = 3'd1;
   localparam logic [2:0] KeyBMiddle = 3'd2;
   localparam logic [2:0] KeyBLeft   = 3'd3;
   localparam logic [2:0] KeyBRight  = 3'd4;
   localparam logic [2:0] KeyBUp     = 3'd5;

   // register indexes
   localparam logic [2:0] RegLadderAEnable = 3'd0;
   localparam logic [2:0] RegLadderBEnable = 3'd1;
   localparam logic [2:0] RegUseRemote     = 3'd2;
   localparam logic [2:0] RegLongPressMs   = 3'd3;
   localparam logic [2:0] RegRepeatMs      = 3'd4;
   localparam logic [2:0] RegHoldTicks     = 3'd5;

   // register reset values
   localparam logic [15:0] LongPressMsReset = 16'd1500;
   localparam logic [15:0] RepeatMsReset    = 16'd500;
   localparam logic [8:0]  HoldTicksReset   = 9'd300;

   // press status encoding
   typedef enum logic [1:0] {
      StNone   = 2'd0,
      StShort  = 2'd1,
      StLong   = 2'd2,
      StRepeat = 2'd3
   } press_status_type;

   // timing settings shared by all lanes
   typedef struct packed {
      logic [15:0] long_press_ms;
      logic [15:0] repeat_ms;
      logic [8:0]  hold_ticks;
   } timing_cfg_type;

   // what one key lane reports for a request
   typedef struct packed {
      press_status_type status;
      logic             short_beep;
      logic             long_beep;
   } lane_out_type;

endpackage

// ===== rtl/rlkpc_decode.sv =====
// sample pair selection and threshold binning for both ladders
module rlkpc_decode (
   input  logic                                 use_remote,
   input  logic [rlkpc_pkg::SampleBits-1:0]     local_a,
   input  logic [rlkpc_pkg::SampleBits-1:0]     local_b,
   input  logic [rlkpc_pkg::SampleBits-1:0]     remote_a,
   input  logic [rlkpc_pkg::SampleBits-1:0]     remote_b,
   output logic [2:0]                           key_code_a,
   output logic [2:0]                           key_code_b
);

   localparam logic [rlkpc_pkg::SampleBits-1:0] T050 = rlkpc_pkg::SampleBits'(rlkpc_pkg::Thr050);
   localparam logic [rlkpc_pkg::SampleBits-1:0] T135 = rlkpc_pkg::SampleBits'(rlkpc_pkg::Thr135);
   localparam logic [rlkpc_pkg::SampleBits-1:0] T170 = rlkpc_pkg::SampleBits'(rlkpc_pkg::Thr170);
   localparam logic [rlkpc_pkg::SampleBits-1:0] T210 = rlkpc_pkg::SampleBits'(rlkpc_pkg::Thr210);
   localparam logic [rlkpc_pkg::SampleBits-1:0] T240 = rlkpc_pkg::SampleBits'(rlkpc_pkg::Thr240);
   localparam logic [rlkpc_pkg::SampleBits-1:0] T300 = rlkpc_pkg::SampleBits'(rlkpc_pkg::Thr300);

   logic [rlkpc_pkg::SampleBits-1:0] sample_a;
   logic [rlkpc_pkg::SampleBits-1:0] sample_b;

   // pick local or remote pair
   assign sample_a = use_remote ? remote_a : local_a;
   assign sample_b = use_remote ? remote_b : local_b;

   // ladder a bins, the 1.35 v limit is not used here
   always_comb begin
      if (sample_a <= T050) begin
         key_code_a = rlkpc_pkg::KeyNone;
      end else if (sample_a <= T170) begin
         key_code_a = rlkpc_pkg::KeyA4;
      end else if (sample_a <= T210) begin
         key_code_a = rlkpc_pkg::KeyA2;
      end else if (sample_a <= T240) begin
         key_code_a = rlkpc_pkg::KeyA3;
      end else if (sample_a <= T300) begin
         key_code_a = rlkpc_pkg::KeyA1;
      end else begin
         key_code_a = rlkpc_pkg::KeyNone;
      end
   end

   // ladder b bins
   always_comb begin
      if (sample_b <= T050) begin
         key_code_b = rlkpc_pkg::KeyNone;
      end else if (sample_b <= T135) begin
         key_code_b = rlkpc_pkg::KeyBUp;
      end else if (sample_b <= T170) begin
         key_code_b = rlkpc_pkg::KeyBRight;
      end else if (sample_b <= T210) begin
         key_code_b = rlkpc_pkg::KeyBLeft;
      end else if (sample_b <= T240) begin
         key_code_b = rlkpc_pkg::KeyBMiddle;
      end else if (sample_b <= T300) begin
         key_code_b = rlkpc_pkg::KeyBDown;
      end else begin
         key_code_b = rlkpc_pkg::KeyNone;
      end
   end

endmodule

// ===== rtl/rlkpc_lane.sv =====
// per-key press tracker: press and repeat timers, status and hold counter
module rlkpc_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              pressed,
   input  logic [rlkpc_pkg::TimeBits-1:0]    now,
   input  rlkpc_pkg::timing_cfg_type         cfg,
   output rlkpc_pkg::lane_out_type           lane_out
);

   logic                              prev_pressed_ff, prev_pressed_in;
   logic [rlkpc_pkg::TimeBits-1:0]    press_start_ff, press_start_in;
   logic [rlkpc_pkg::TimeBits-1:0]    repeat_start_ff, repeat_start_in;
   rlkpc_pkg::press_status_type       status_ff, status_in;
   logic [8:0]                        hold_count_ff, hold_count_in;

   logic [rlkpc_pkg::TimeBits-1:0]    since_press;
   logic [rlkpc_pkg::TimeBits-1:0]    since_repeat;
   rlkpc_pkg::press_status_type       status_mid;
   logic [8:0]                        hold_mid;
   logic                              short_hit;
   logic                              long_hit;

   // elapsed times, modulo the time width
   assign since_press  = now - press_start_ff;
   assign since_repeat = now - repeat_start_ff;

   // next state for one request
   always_comb begin
      prev_pressed_in = prev_pressed_ff;
      press_start_in  = press_start_ff;
      repeat_start_in = repeat_start_ff;
      status_mid      = status_ff;
      hold_mid        = hold_count_ff;
      status_in       = status_ff;
      hold_count_in   = hold_count_ff;
      short_hit       = 1'b0;
      long_hit        = 1'b0;
      if (advance) begin
         // edge handling
         if (pressed) begin
            if (!prev_pressed_ff) begin
               press_start_in  = now;
               repeat_start_in = now;
            end else if (since_repeat > rlkpc_pkg::TimeBits'(cfg.repeat_ms)) begin
               repeat_start_in = now;
               status_mid      = rlkpc_pkg::StRepeat;
            end
         end else if (prev_pressed_ff) begin
            if (since_press > rlkpc_pkg::TimeBits'(cfg.long_press_ms)) begin
               status_mid = rlkpc_pkg::StLong;
               long_hit   = 1'b1;
            end else begin
               status_mid = rlkpc_pkg::StShort;
               short_hit  = 1'b1;
            end
            hold_mid = 9'd0;
         end
         prev_pressed_in = pressed;
         // short and long status expire after the hold count
         status_in     = status_mid;
         hold_count_in = hold_mid;
         if (status_mid == rlkpc_pkg::StShort || status_mid == rlkpc_pkg::StLong) begin
            hold_count_in = hold_mid + 9'd1;
            if (hold_count_in >= cfg.hold_ticks) begin
               status_in     = rlkpc_pkg::StNone;
               hold_count_in = 9'd0;
            end
         end
      end
   end

   // key state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pressed_ff <= 1'b0;
         press_start_ff  <= '0;
         repeat_start_ff <= '0;
         status_ff       <= rlkpc_pkg::StNone;
         hold_count_ff   <= 9'd0;
      end else begin
         prev_pressed_ff <= prev_pressed_in;
         press_start_ff  <= press_start_in;
         repeat_start_ff <= repeat_start_in;
         status_ff       <= status_in;
         hold_count_ff   <= hold_count_in;
      end
   end

   assign lane_out.status     = status_in;
   assign lane_out.short_beep = short_hit;
   assign lane_out.long_beep  = long_hit;

endmodule

// ===== rtl/resistor_ladder_key_press_classifier.sv =====
// top level: settings, sample decode, nine key lanes, status merge and response register
//
//   channel | direction | handshake            | contents
//   req     | in        | req_valid/req_ready  | time and four adc samples
//   rsp     | out       | rsp_valid/rsp_ready  | key codes, status words, beeps
//   csr     | in        | csr_wr_en            | register index and write data
//
// each request is handled combinationally: decode, all nine lanes and the merge run in
// parallel and land in the response register on the accepting edge.
// a new request is taken every cycle while the response register is empty or
// being drained; a stalled response holds the next request off.
// synchronous reset clears key state and the response valid and returns the settings to their reset values.
module resistor_ladder_key_press_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic [11:0] req_local_sample_a,
   input  logic [11:0] req_local_sample_b,
   input  logic [11:0] req_remote_sample_a,
   input  logic [11:0] req_remote_sample_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_key_code_a,
   output logic [2:0]  rsp_key_code_b,
   output logic [7:0]  rsp_status_a,
   output logic [9:0]  rsp_status_b,
   output logic        rsp_short_beep,
   output logic        rsp_long_beep,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic        ladder_a_enable_ff;
   logic        ladder_b_enable_ff;
   logic        use_remote_ff;
   logic [15:0] long_press_ms_ff;
   logic [15:0] repeat_ms_ff;
   logic [8:0]  hold_ticks_ff;

   rlkpc_pkg::timing_cfg_type         timing_cfg;
   logic                              accept;
   logic [rlkpc_pkg::TimeBits-1:0]    now_t;
   logic [2:0]                        key_code_a;
   logic [2:0]                        key_code_b;
   rlkpc_pkg::lane_out_type           lane_out [rlkpc_pkg::NumKeys];

   logic [2*rlkpc_pkg::NumKeysA-1:0]  status_a_in;
   logic [2*rlkpc_pkg::NumKeysB-1:0]  status_b_in;
   logic                              short_beep_in;
   logic                              long_beep_in;

   logic                              rsp_valid_ff;
   logic [2:0]                        key_code_a_ff;
   logic [2:0]                        key_code_b_ff;
   logic [7:0]                        status_a_ff;
   logic [9:0]                        status_b_ff;
   logic                              short_beep_ff;
   logic                              long_beep_ff;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ladder_a_enable_ff <= 1'b0;
         ladder_b_enable_ff <= 1'b0;
         use_remote_ff      <= 1'b0;
         long_press_ms_ff   <= rlkpc_pkg::LongPressMsReset;
         repeat_ms_ff       <= rlkpc_pkg::RepeatMsReset;
         hold_ticks_ff      <= rlkpc_pkg::HoldTicksReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            rlkpc_pkg::RegLadderAEnable: ladder_a_enable_ff <= csr_wdata[0];
            rlkpc_pkg::RegLadderBEnable: ladder_b_enable_ff <= csr_wdata[0];
            rlkpc_pkg::RegUseRemote:     use_remote_ff      <= csr_wdata[0];
            rlkpc_pkg::RegLongPressMs:   long_press_ms_ff   <= csr_wdata;
            rlkpc_pkg::RegRepeatMs:      repeat_ms_ff       <= csr_wdata;
            rlkpc_pkg::RegHoldTicks:     hold_ticks_ff      <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   assign timing_cfg.long_press_ms = long_press_ms_ff;
   assign timing_cfg.repeat_ms     = repeat_ms_ff;
   assign timing_cfg.hold_ticks    = hold_ticks_ff;

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign now_t     = rlkpc_pkg::TimeBits'(req_now_ms);

   // sample decode
   rlkpc_decode u_decode (
      .use_remote (use_remote_ff),
      .local_a    (rlkpc_pkg::SampleBits'(req_local_sample_a)),
      .local_b    (rlkpc_pkg::SampleBits'(req_local_sample_b)),
      .remote_a   (rlkpc_pkg::SampleBits'(req_remote_sample_a)),
      .remote_b   (rlkpc_pkg::SampleBits'(req_remote_sample_b)),
      .key_code_a (key_code_a),
      .key_code_b (key_code_b)
   );

   // key lanes, ladder a first then ladder b
   for (genvar i = 0; i < rlkpc_pkg::NumKeys; i++) begin : g_lane
      logic lane_pressed;
      logic lane_advance;
      if (i < rlkpc_pkg::NumKeysA) begin : g_a
         assign lane_pressed = (key_code_a == 3'(i + 1));
         assign lane_advance = accept && ladder_a_enable_ff;
      end else begin : g_b
         assign lane_pressed = (key_code_b == 3'(i - rlkpc_pkg::NumKeysA + 1));
         assign lane_advance = accept && ladder_b_enable_ff;
      end
      rlkpc_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .advance  (lane_advance),
         .pressed  (lane_pressed),
         .now      (now_t),
         .cfg      (timing_cfg),
         .lane_out (lane_out[i])
      );
   end

   // merge lane results into status words and beep flags
   always_comb begin
      short_beep_in = 1'b0;
      long_beep_in  = 1'b0;
      for (int k = 0; k < rlkpc_pkg::NumKeysA; k++) begin
         status_a_in[2*k +: 2] = lane_out[k].status;
      end
      for (int k = 0; k < rlkpc_pkg::NumKeysB; k++) begin
         status_b_in[2*k +: 2] = lane_out[rlkpc_pkg::NumKeysA + k].status;
      end
      for (int k = 0; k < rlkpc_pkg::NumKeys; k++) begin
         short_beep_in = short_beep_in | lane_out[k].short_beep;
         long_beep_in  = long_beep_in  | lane_out[k].long_beep;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         rsp_valid_ff <= req_valid;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         key_code_a_ff <= key_code_a;
         key_code_b_ff <= key_code_b;
         status_a_ff   <= status_a_in;
         status_b_ff   <= status_b_in;
         short_beep_ff <= short_beep_in;
         long_beep_ff  <= long_beep_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_code_a = key_code_a_ff;
   assign rsp_key_code_b = key_code_b_ff;
   assign rsp_status_a   = status_a_ff;
   assign rsp_status_b   = status_b_ff;
   assign rsp_short_beep = short_beep_ff;
   assign rsp_long_beep  = long_beep_ff;

endmodule
